[rtl/bmlr_pkg.sv]
// Shared types and constants for the binary matrix largest rectangle block.
`timescale 1ns / 1ps
`default_nettype none
package bmlr_pkg;

  localparam int ROW_W  = 64;
  localparam int AREA_W = 16;
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [AREA_W-1:0] AREA_MAX  = '1;
  localparam logic [CFG_W-1:0]  COLS_RST  = 7'd64;
  localparam logic              REG_COLS  = 1'b0;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic prep;
    logic clr_all;
    logic h_we;
    logic lb_we;
  } cs_ctl_t;

endpackage
`default_nettype wire

[rtl/bmlr_stack.sv]
// Monotonic index stack: top entry in registers, lower entries in a memory.
`timescale 1ns / 1ps
`default_nettype none
module bmlr_stack #(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int CW    = 7,
  parameter int HW    = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmlr_pkg::stk_cmd_t  cmd,
  input  logic [IW-1:0]       push_idx,
  input  logic [HW-1:0]       push_h,
  output logic                nz,
  output logic [IW-1:0]       tos_idx,
  output logic [HW-1:0]       tos_h
);

  localparam int EW = IW + HW;

  logic [EW-1:0] mem [DEPTH];
  logic [CW-1:0] cnt_r;
  logic [EW-1:0] tos_r;
  logic [EW-1:0] hold_r;
  logic [EW-1:0] rd_r;
  logic          sel_r;
  logic [EW-1:0] below;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  assign below   = sel_r ? rd_r : hold_r;
  assign waddr   = IW'(cnt_r - CW'(1));
  assign raddr   = IW'(cnt_r - CW'(3));
  assign nz      = (cnt_r != '0);
  assign tos_idx = tos_r[EW-1:HW];
  assign tos_h   = tos_r[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sel_r <= 1'b0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
    end else if (cmd.push) begin
      cnt_r <= cnt_r + CW'(1);
      sel_r <= 1'b0;
    end else if (cmd.pop) begin
      cnt_r <= cnt_r - CW'(1);
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      tos_r  <= {push_idx, push_h};
      hold_r <= tos_r;
      if (cnt_r != '0) begin
        mem[waddr] <= tos_r;
      end
    end else if (cmd.pop && !cmd.clear) begin
      tos_r <= below;
    end
    rd_r <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/bmlr_colstore.sv]
// Column height memory with valid bits, and left boundary memory.
`timescale 1ns / 1ps
`default_nettype none
module bmlr_colstore #(
  parameter int N  = 64,
  parameter int IW = 6,
  parameter int CW = 7,
  parameter int HW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bmlr_pkg::cs_ctl_t  ctl,
  input  logic [CW-1:0]      cnt,
  input  logic [IW-1:0]      waddr,
  input  logic [IW-1:0]      raddr,
  input  logic [HW-1:0]      wr_h,
  input  logic [IW-1:0]      wr_lb,
  output logic [HW-1:0]      rd_h,
  output logic [IW-1:0]      rd_lb
);

  logic [HW-1:0] hmem  [N];
  logic [IW-1:0] lbmem [N];
  logic [N-1:0]  valid_r;
  logic [N-1:0]  valid_nxt;
  logic [N-1:0]  keep;
  logic [HW-1:0] rd_h_r;
  logic [IW-1:0] rd_lb_r;

  assign rd_h  = rd_h_r;
  assign rd_lb = rd_lb_r;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      keep[j] = (CW'(j) < cnt);
    end
    valid_nxt = valid_r;
    if (ctl.prep) begin
      valid_nxt = valid_r & keep & {N{~ctl.clr_all}};
    end
    if (ctl.h_we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.h_we) begin
      hmem[waddr] <= wr_h;
    end
    if (ctl.lb_we) begin
      lbmem[waddr] <= wr_lb;
    end
    rd_h_r  <= valid_r[raddr] ? hmem[raddr] : '0;
    rd_lb_r <= lbmem[raddr];
  end

endmodule
`default_nettype wire

[rtl/bmlr_area.sv]
// Area unit: height times width, saturate, keep the row maximum.
`timescale 1ns / 1ps
`default_nettype none
module bmlr_area #(
  parameter int HW = 10,
  parameter int CW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          in_v,
  input  logic [HW-1:0]                 h,
  input  logic [CW-1:0]                 w,
  output logic                          busy,
  output logic [bmlr_pkg::AREA_W-1:0]   best
);

  localparam int PW = HW + CW;

  logic [PW-1:0]                 prod_r;
  logic                          v1_r;
  logic [bmlr_pkg::AREA_W-1:0]   best_r;
  logic [bmlr_pkg::AREA_W-1:0]   a16;

  assign busy = v1_r;
  assign best = best_r;
  assign a16  = (prod_r > PW'(bmlr_pkg::AREA_MAX)) ? bmlr_pkg::AREA_MAX
                                                   : bmlr_pkg::AREA_W'(prod_r);

  always_ff @(posedge clk) begin
    prod_r <= PW'(h) * PW'(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      best_r <= '0;
    end else begin
      v1_r <= in_v;
      if (clear) begin
        best_r <= '0;
      end else if (v1_r && (a16 > best_r)) begin
        best_r <= a16;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/binary_matrix_largest_rectangle_top.sv]
// Top level: row sequencer, configuration port and result register.
// Usage:
//   Send one matrix row per transaction on in_valid/in_ready: in_row_bits holds
//   the cells, bit j for column j, and in_first_row starts a new matrix.
//   One result transaction per row comes out on out_valid/out_ready: the row's
//   largest rectangle area, the best area of the matrix so far, and a flag
//   for a column height held at MAX_HEIGHT.
//   The column count is set through the APB port (register 0, byte 0),
//   reset value 64; write it only while the block is idle.
//   From acceptance to result a row passes the start state, a left sweep,
//   the right-start state and a right sweep of a shared stack compare, each
//   sweep with a step per column plus one per stack pop, then the drain of
//   the area pipeline (product and maximum registers) and the load of the
//   result register. A column count of zero goes straight to the result.
//   in_ready is low while a row is in work, so no new row is taken before
//   the previous one is through.
//   The result register frees the input side: a new row is accepted while a
//   result waits; a stalled receiver only holds the next row at its end.
//   Reset clears the histogram valid bits and the best area and sets the
//   column count to 64 directly; no clearing sweep.
`timescale 1ns / 1ps
`default_nettype none
module binary_matrix_largest_rectangle_top #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_HEIGHT  = 1023
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmlr_pkg::ROW_W-1:0]    in_row_bits,
  input  logic                          in_first_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmlr_pkg::AREA_W-1:0]   out_row_area,
  output logic [bmlr_pkg::AREA_W-1:0]   out_best_area,
  output logic                          out_height_saturated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmlr_pkg::APB_AW-1:0]   paddr,
  input  logic [bmlr_pkg::APB_DW-1:0]   pwdata,
  output logic [bmlr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [HW-1:0] HMAX = HW'(MAX_HEIGHT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_LEFT   = 3'd2;
  localparam logic [2:0] S_RSTART = 3'd3;
  localparam logic [2:0] S_RIGHT  = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [IW-1:0]                 i_r, i_nxt;
  logic                          fresh_r, fresh_nxt;
  logic [bmlr_pkg::ROW_W-1:0]    bits_r;
  logic [CW-1:0]                 cnt_r;
  logic [HW-1:0]                 cur_h_r;
  logic [IW-1:0]                 cur_lb_r;
  logic                          held_r;
  logic [bmlr_pkg::AREA_W-1:0]   best_r;
  logic [bmlr_pkg::CFG_W-1:0]    cols_r;
  logic                          out_valid_r;
  logic [bmlr_pkg::AREA_W-1:0]   out_area_r;
  logic [bmlr_pkg::AREA_W-1:0]   out_best_r;
  logic                          out_sat_r;

  logic [CW-1:0]                 cnt_in;
  logic                          acc;
  logic                          cfg_wr;
  logic                          out_free;
  bmlr_pkg::stk_cmd_t            stk_cmd;
  bmlr_pkg::cs_ctl_t             cs_ctl;
  logic [IW-1:0]                 cs_raddr;
  logic [HW-1:0]                 cs_rd_h;
  logic [IW-1:0]                 cs_rd_lb;
  logic                          stk_nz;
  logic [IW-1:0]                 stk_tos_idx;
  logic [HW-1:0]                 stk_tos_h;
  logic                          area_v;
  logic                          area_busy;
  logic [bmlr_pkg::AREA_W-1:0]   row_best;
  logic [bmlr_pkg::AREA_W-1:0]   best_nxt;

  logic                          col_on;
  logic                          hsat;
  logic [HW-1:0]                 new_h;
  logic [HW-1:0]                 h_now;
  logic [IW-1:0]                 lb_now;
  logic                          pop_hit;
  logic                          last_i;
  logic [IW-1:0]                 lb_new;
  logic [CW-1:0]                 r_bound;
  logic [CW-1:0]                 width;

  assign in_ready             = (state_r == S_IDLE);
  assign acc                  = in_valid && in_ready;
  assign out_valid            = out_valid_r;
  assign out_row_area         = out_area_r;
  assign out_best_area        = out_best_r;
  assign out_height_saturated = out_sat_r;
  assign out_free             = !out_valid_r || out_ready;
  assign pready               = 1'b1;
  assign cfg_wr               = psel && penable && pwrite;
  assign prdata = (paddr[bmlr_pkg::APB_AW-1] == bmlr_pkg::REG_COLS)
                  ? bmlr_pkg::APB_DW'(cols_r) : '0;

  assign cnt_in = (cols_r > bmlr_pkg::CFG_W'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                            : CW'(cols_r);

  assign col_on  = bits_r[i_r];
  assign hsat    = (cs_rd_h >= HMAX);
  assign new_h   = col_on ? (hsat ? HMAX : cs_rd_h + HW'(1)) : '0;
  assign h_now   = (state_r == S_LEFT) ? (fresh_r ? new_h : cur_h_r)
                                       : (fresh_r ? cs_rd_h : cur_h_r);
  assign lb_now  = fresh_r ? cs_rd_lb : cur_lb_r;
  assign pop_hit = stk_nz && (stk_tos_h >= h_now);
  assign last_i  = (CW'(i_r) == cnt_r - CW'(1));
  assign lb_new  = stk_nz ? stk_tos_idx + IW'(1) : '0;
  assign r_bound = stk_nz ? CW'(stk_tos_idx) : cnt_r;
  assign width   = r_bound - CW'(lb_now);
  assign best_nxt = (row_best > best_r) ? row_best : best_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    fresh_nxt = fresh_r;
    stk_cmd   = '0;
    cs_ctl    = '0;
    cs_raddr  = i_r;
    area_v    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cs_ctl.prep    = 1'b1;
          cs_ctl.clr_all = in_first_row;
          stk_cmd.clear  = 1'b1;
          i_nxt          = '0;
          state_nxt      = (cnt_in == '0) ? S_FINISH : S_START;
        end
      end
      S_START: begin
        cs_raddr  = '0;
        fresh_nxt = 1'b1;
        state_nxt = S_LEFT;
      end
      S_LEFT: begin
        cs_ctl.h_we = fresh_r;
        if (pop_hit) begin
          stk_cmd.pop = 1'b1;
          fresh_nxt   = 1'b0;
        end else begin
          cs_ctl.lb_we = 1'b1;
          if (last_i) begin
            stk_cmd.clear = 1'b1;
            state_nxt     = S_RSTART;
          end else begin
            stk_cmd.push = 1'b1;
            i_nxt        = i_r + IW'(1);
            cs_raddr     = i_r + IW'(1);
            fresh_nxt    = 1'b1;
          end
        end
      end
      S_RSTART: begin
        fresh_nxt = 1'b1;
        state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        if (pop_hit) begin
          stk_cmd.pop = 1'b1;
          fresh_nxt   = 1'b0;
        end else begin
          area_v       = 1'b1;
          stk_cmd.push = 1'b1;
          fresh_nxt    = 1'b1;
          if (i_r == '0) begin
            state_nxt = S_DRAIN;
          end else begin
            i_nxt    = i_r - IW'(1);
            cs_raddr = i_r - IW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!area_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      fresh_r     <= 1'b0;
      held_r      <= 1'b0;
      best_r      <= '0;
      cols_r      <= bmlr_pkg::COLS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      fresh_r <= fresh_nxt;
      if (cfg_wr && (paddr[bmlr_pkg::APB_AW-1] == bmlr_pkg::REG_COLS)) begin
        cols_r <= pwdata[bmlr_pkg::CFG_W-1:0];
      end
      if (acc) begin
        held_r <= 1'b0;
        if (in_first_row) begin
          best_r <= '0;
        end
      end else if ((state_r == S_LEFT) && fresh_r) begin
        held_r <= held_r | (col_on & hsat);
      end
      if ((state_r == S_FINISH) && out_free) begin
        best_r      <= best_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bits_r <= in_row_bits;
      cnt_r  <= cnt_in;
    end
    if (fresh_r && (state_r == S_LEFT)) begin
      cur_h_r <= new_h;
    end else if (fresh_r && (state_r == S_RIGHT)) begin
      cur_h_r  <= cs_rd_h;
      cur_lb_r <= cs_rd_lb;
    end
    if ((state_r == S_FINISH) && out_free) begin
      out_area_r <= row_best;
      out_best_r <= best_nxt;
      out_sat_r  <= held_r;
    end
  end

  bmlr_colstore #(
    .N  (MAX_COLUMNS),
    .IW (IW),
    .CW (CW),
    .HW (HW)
  ) u_colstore (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cs_ctl),
    .cnt   (cnt_in),
    .waddr (i_r),
    .raddr (cs_raddr),
    .wr_h  (new_h),
    .wr_lb (lb_new),
    .rd_h  (cs_rd_h),
    .rd_lb (cs_rd_lb)
  );

  bmlr_stack #(
    .DEPTH (MAX_COLUMNS),
    .IW    (IW),
    .CW    (CW),
    .HW    (HW)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (stk_cmd),
    .push_idx (i_r),
    .push_h   (h_now),
    .nz       (stk_nz),
    .tos_idx  (stk_tos_idx),
    .tos_h    (stk_tos_h)
  );

  bmlr_area #(
    .HW (HW),
    .CW (CW)
  ) u_area (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (acc),
    .in_v  (area_v),
    .h     (h_now),
    .w     (width),
    .busy  (area_busy),
    .best  (row_best)
  );

endmodule
`default_nettype wire

[rtl/bmlr_checker.sv]
// Port-level checks for the largest rectangle block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bmlr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmlr_pkg::AREA_W-1:0]   out_row_area,
  input logic [bmlr_pkg::AREA_W-1:0]   out_best_area,
  input logic                          out_height_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_area) &&
      $stable(out_best_area) && $stable(out_height_saturated))
    else $error("result transaction changed while stalled");

  a_best_covers_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_area >= out_row_area)
    else $error("best area below row area");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a row is in work");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind binary_matrix_largest_rectangle_top bmlr_checker u_bmlr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_row_area         (out_row_area),
  .out_best_area        (out_best_area),
  .out_height_saturated (out_height_saturated)
);
`default_nettype wire
